[hdl/gsmf_pkg.sv]
package gsmf_pkg;

    localparam int NameBytesMax = 8;
    localparam int CfgW         = 64;
    localparam int CfgIdxW      = 2;
    localparam int NameW        = NameBytesMax * 8;
    localparam int TotalW       = 17;

    localparam logic [31:0]       CrcPoly  = 32'hEDB88320;
    localparam logic [31:0]       CrcInit  = 32'hFFFFFFFF;
    localparam logic [TotalW-1:0] TotalMax = 17'h1FFFF;

    localparam logic [7:0] GzId1    = 8'h1F;
    localparam logic [7:0] GzId2    = 8'h8B;
    localparam logic [7:0] GzCmDefl = 8'h08;
    localparam logic [7:0] FlgFname = 8'h08;
    localparam logic [7:0] FlgNone  = 8'h00;
    localparam logic [7:0] GzXfl    = 8'h02;
    localparam logic [7:0] GzOs     = 8'h00;
    localparam logic [7:0] BlkFinal = 8'h01;

    localparam logic [3:0] HdrLast = 4'd9;
    localparam logic [3:0] BlkLast = 4'd4;
    localparam logic [3:0] TrlLast = 4'd7;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_NAME_CHARS   = 2'd0,
        CFG_NAME_LEN     = 2'd1,
        CFG_BLOCK_LENGTH = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_NAME,
        PH_NUL,
        PH_BLK,
        PH_DATA,
        PH_TRL
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       member_end;
        logic       length_error;
    } t_out_word;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic              hdr;
        logic [3:0]        nl;
        logic [NameW-1:0]  name;
        logic [15:0]       len;
        logic [31:0]       crc;
        logic [TotalW-1:0] total;
        logic              err;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/gzip_stored_member_framer.sv]
// Wraps data words into one gzip member with a single final stored block: the first
// word of a member brings the gzip header, the optional name with its NUL, and the
// stored-block header; each word then passes through, and the last is followed by
// CRC-32 and ISIZE. A new word is taken every cycle while the two-entry job queue has
// room; the output sequencer sends one byte per cycle unless i_out_ready stalls it.
// A plain data word gives one byte, a member's first word 15 extra plus name length plus
// one if named, its last word 8 extra; the CRC is done in the cycle a word is taken.
module gzip_stored_member_framer
    import gsmf_pkg::*;
#(
    parameter int NAME_BYTES = NameBytesMax
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out
);

    logic    w_push;
    logic    w_pop;
    t_job    w_job_in;
    t_job    w_job_head;
    t_q_stat w_q_stat;

    gsmf_front #(
        .NAME_BYTES (NAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_q_stat   (w_q_stat),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    gsmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_head  (w_job_head)
    );

    gsmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_job       (w_job_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.valid)
        else $error("queue popped while empty");

    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_q_stat.valid)
        else $error("input stalled with empty queue");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.member_end) |-> o_out.run_last)
        else $error("member end without run last");

    a_err_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.length_error) |-> o_out.member_end)
        else $error("length error outside member end");
`endif

endmodule

[hdl/gsmf_front.sv]
module gsmf_front
    import gsmf_pkg::*;
#(
    parameter int NAME_BYTES = NameBytesMax
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    input  t_in_word           i_in,
    input  t_q_stat            i_q_stat,
    output logic               o_in_ready,
    output logic               o_push,
    output t_job               o_job
);

    localparam logic [3:0] NameMax = 4'(NAME_BYTES);

    logic [NAME_BYTES*8-1:0] r_name_chars;
    logic [3:0]              r_name_len;
    logic [15:0]             r_blen;
    logic [31:0]             r_crc,   n_crc;
    logic [TotalW-1:0]       r_total, n_total;
    logic                    r_inside;
    logic [31:0]             w_crc_new;
    logic [TotalW-1:0]       w_total_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_chars <= '0;
            r_name_len   <= '0;
            r_blen       <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NAME_CHARS:   r_name_chars <= i_cfg_data[NAME_BYTES*8-1:0];
                CFG_NAME_LEN:     r_name_len   <= i_cfg_data[3:0];
                CFG_BLOCK_LENGTH: r_blen       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready  = !i_q_stat.full;
    assign o_push      = i_in_valid && o_in_ready;
    assign w_crc_new   = crc_byte(r_crc, i_in.data_byte);
    assign w_total_new = (r_total == TotalMax) ? r_total : r_total + 1'b1;

    always_comb begin
        n_crc   = i_in.last_byte ? CrcInit : w_crc_new;
        n_total = i_in.last_byte ? '0 : w_total_new;
    end

    always_comb begin
        o_job.data  = i_in.data_byte;
        o_job.last  = i_in.last_byte;
        o_job.hdr   = !r_inside;
        o_job.nl    = (r_name_len > NameMax) ? NameMax : r_name_len;
        o_job.name  = NameW'(r_name_chars);
        o_job.len   = r_blen;
        o_job.crc   = ~w_crc_new;
        o_job.total = w_total_new;
        o_job.err   = w_total_new != {1'b0, r_blen};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CrcInit;
            r_total  <= '0;
            r_inside <= 1'b0;
        end else if (o_push) begin
            r_crc    <= n_crc;
            r_total  <= n_total;
            r_inside <= !i_in.last_byte;
        end
    end

endmodule

[hdl/gsmf_queue.sv]
module gsmf_queue
    import gsmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_job    o_head
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_stat.valid = r_cnt != 2'd0;
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[hdl/gsmf_back.sv]
module gsmf_back
    import gsmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_stat   i_q_stat,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    t_phase     r_phase, n_phase, w_phase;
    logic [3:0] r_idx,   n_idx,   w_idx;
    logic       r_busy;
    logic       w_done;
    logic       w_adv;
    logic [7:0] w_byte;
    logic [31:0] w_total32;
    t_out_word  r_out;
    logic       r_ovalid;

    assign w_adv     = i_q_stat.valid && (!r_ovalid || i_out_ready);
    assign o_pop     = w_adv && w_done;
    assign w_phase   = r_busy ? r_phase : (i_job.hdr ? PH_HDR : PH_DATA);
    assign w_idx     = r_busy ? r_idx : 4'd0;
    assign w_total32 = 32'(i_job.total);

    always_comb begin
        n_phase = w_phase;
        n_idx   = w_idx + 4'd1;
        w_done  = 1'b0;
        unique case (w_phase)
            PH_HDR: begin
                if (w_idx == HdrLast) begin
                    n_idx   = 4'd0;
                    n_phase = (i_job.nl != 4'd0) ? PH_NAME : PH_BLK;
                end
            end
            PH_NAME: begin
                if (w_idx == i_job.nl - 4'd1) begin
                    n_idx   = 4'd0;
                    n_phase = PH_NUL;
                end
            end
            PH_NUL: begin
                n_idx   = 4'd0;
                n_phase = PH_BLK;
            end
            PH_BLK: begin
                if (w_idx == BlkLast) begin
                    n_idx   = 4'd0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_job.last) begin
                    n_idx   = 4'd0;
                    n_phase = PH_TRL;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_TRL: begin
                w_done = w_idx == TrlLast;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_byte = 8'h00;
        unique case (w_phase)
            PH_HDR: begin
                unique case (w_idx)
                    4'd0:    w_byte = GzId1;
                    4'd1:    w_byte = GzId2;
                    4'd2:    w_byte = GzCmDefl;
                    4'd3:    w_byte = (i_job.nl != 4'd0) ? FlgFname : FlgNone;
                    4'd8:    w_byte = GzXfl;
                    4'd9:    w_byte = GzOs;
                    default: w_byte = 8'h00;
                endcase
            end
            PH_NAME: w_byte = i_job.name[{w_idx[2:0], 3'b000} +: 8];
            PH_NUL:  w_byte = 8'h00;
            PH_BLK: begin
                unique case (w_idx)
                    4'd0:    w_byte = BlkFinal;
                    4'd1:    w_byte = i_job.len[7:0];
                    4'd2:    w_byte = i_job.len[15:8];
                    4'd3:    w_byte = ~i_job.len[7:0];
                    default: w_byte = ~i_job.len[15:8];
                endcase
            end
            PH_DATA: w_byte = i_job.data;
            PH_TRL: begin
                w_byte = w_idx[2] ? w_total32[{w_idx[1:0], 3'b000} +: 8]
                                  : i_job.crc[{w_idx[1:0], 3'b000} +: 8];
            end
            default: w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_HDR;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_busy  <= !w_done;
                r_phase <= n_phase;
                r_idx   <= n_idx;
            end
            if (w_adv) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_byte     <= w_byte;
            r_out.run_last     <= w_done;
            r_out.member_end   <= w_done && (w_phase == PH_TRL);
            r_out.length_error <= w_done && (w_phase == PH_TRL) && i_job.err;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule
